// ----- hw/rtl/bpq_pkg.sv -----
// Shared types and constants for the bucket priority queue.
// No dependencies.
package bpq_pkg;
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_POP   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;
endpackage

// ----- hw/rtl/bucket_priority_queue_core.sv -----
// Bucket priority queue top level: sequencer plus bucket head and link memories.
// Depends on bpq_pkg.
//
// Usage: one request channel (kind_i, entry_i, bucket_i) and one result channel
// (entry_out_o, entry_valid_o, already_expanded_o), both valid/stall. Every
// request gives exactly one result.
// Each request runs through a sequencer over synchronous memories with
// registered reads; a new request is taken only when the previous one is done
// and its result has left the output register.
// A push whose bucket already has a head also links that old head back to the
// new one; a move whose bucket is unchanged ends after reading the entry's links
// and recorded bucket; a pop steps past each empty bucket and drops each stale
// head it meets; a pop of an empty queue gives a result with no valid entry.
// The head memory is cleared after reset by a pass over all BUCKETS heads
// during which no request is taken. Link memories are not cleared.
// A stalled result holds in the output register; the block takes nothing new
// until it leaves.
module bucket_priority_queue_core #(
  parameter int ENTRIES = 4096,
  parameter int BUCKETS = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              kind_i,
  input  logic [11:0]             entry_i,
  input  logic [7:0]              bucket_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [11:0]             entry_out_o,
  output logic                    entry_valid_o,
  output logic                    already_expanded_o
);
  import bpq_pkg::*;

  localparam int EW = $clog2(ENTRIES) + 1;   // link width, NIL = ENTRIES
  localparam int EA = $clog2(ENTRIES);
  localparam int BA = $clog2(BUCKETS);
  localparam int BW = BA + 1;
  localparam logic [EW-1:0] NIL = EW'(ENTRIES);
  localparam logic [BW-1:0] BNONE = BW'(BUCKETS);

  typedef enum logic [14:0] {
    S_CLR   = 15'h0001,
    S_IDLE  = 15'h0002,
    S_RD    = 15'h0004,
    S_EVAL  = 15'h0008,
    S_MHD   = 15'h0010,  // move: old head read back
    S_MNX   = 15'h0020,  // move: fix next neighbor
    S_LNK   = 15'h0040,  // link front: read new head
    S_LNK2  = 15'h0080,
    S_QHD   = 15'h0100,
    S_PSCAN = 15'h0200,
    S_PHD   = 15'h0400,
    S_PNX   = 15'h0800,
    S_PCHK  = 15'h1000,
    S_PCHK2 = 15'h2000,
    S_OUT   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // memories
  logic [EW-1:0] head_mem [BUCKETS];
  logic [EW-1:0] next_mem [ENTRIES];
  logic [EW-1:0] prev_mem [ENTRIES];
  logic [BA-1:0] bkt_mem  [ENTRIES];

  logic          h_we;  logic [BA-1:0] h_wa, h_ra; logic [EW-1:0] h_wd, h_rd;
  logic          n_we;  logic [EA-1:0] n_wa, n_ra; logic [EW-1:0] n_wd, n_rd;
  logic          p_we;  logic [EA-1:0] p_wa, p_ra; logic [EW-1:0] p_wd, p_rd;
  logic          b_we;  logic [EA-1:0] b_wa, b_ra; logic [BA-1:0] b_wd, b_rd;

  always_ff @(posedge clk_i) begin
    if (h_we) head_mem[h_wa] <= h_wd;
    h_rd <= head_mem[h_ra];
  end
  always_ff @(posedge clk_i) begin
    if (n_we) next_mem[n_wa] <= n_wd;
    n_rd <= next_mem[n_ra];
  end
  always_ff @(posedge clk_i) begin
    if (p_we) prev_mem[p_wa] <= p_wd;
    p_rd <= prev_mem[p_ra];
  end
  always_ff @(posedge clk_i) begin
    if (b_we) bkt_mem[b_wa] <= b_wd;
    b_rd <= bkt_mem[b_ra];
  end

  logic [1:0]    kind_q, kind_d;
  logic [EA-1:0] ent_q, ent_d;
  logic [BA-1:0] bkt_q, bkt_d;
  logic          ok_q, ok_d;
  logic [BW-1:0] low_q, low_d;
  logic [EW-1:0] nx_q, nx_d, pv_q, pv_d;
  logic [BA-1:0] ob_q, ob_d;
  logic [BA-1:0] clr_q, clr_d;
  logic [EA-1:0] res_e_q, res_e_d;
  logic          res_v_q, res_v_d, res_x_q, res_x_d;

  logic e_ok, b_ok;
  assign e_ok = ({20'd0, entry_i} < 32'(ENTRIES));
  assign b_ok = ({24'd0, bucket_i} < 32'(BUCKETS));

  function automatic logic is_ent(logic [EW-1:0] v);
    return v != NIL && !v[EW-1];
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign entry_out_o = 12'(res_e_q);
  assign entry_valid_o = res_v_q;
  assign already_expanded_o = res_x_q;

  always_comb begin
    state_d = state_q; kind_d = kind_q; ent_d = ent_q; bkt_d = bkt_q; ok_d = ok_q;
    low_d = low_q; nx_d = nx_q; pv_d = pv_q; ob_d = ob_q; clr_d = clr_q;
    res_e_d = res_e_q; res_v_d = res_v_q; res_x_d = res_x_q;
    h_we = 1'b0; h_wa = '0; h_wd = NIL; h_ra = '0;
    n_we = 1'b0; n_wa = ent_q; n_wd = NIL; n_ra = ent_q;
    p_we = 1'b0; p_wa = ent_q; p_wd = NIL; p_ra = ent_q;
    b_we = 1'b0; b_wa = ent_q; b_wd = bkt_q; b_ra = ent_q;
    case (state_q)
      S_CLR: begin
        h_we = 1'b1; h_wa = clr_q; h_wd = NIL;
        clr_d = clr_q + 1'b1;
        if (clr_q == BA'(BUCKETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i;
          ent_d = EA'(entry_i);
          bkt_d = BA'(bucket_i);
          ok_d = e_ok && (b_ok || kind_i == KIND_QUERY);
          res_e_d = '0; res_v_d = 1'b0; res_x_d = 1'b0;
          state_d = (kind_i == KIND_POP) ? S_PSCAN : S_RD;
        end
      end
      S_RD: begin
        // read entry links and recorded bucket
        if (!ok_q) state_d = S_OUT;
        else if (kind_q == KIND_PUSH) begin
          b_we = 1'b1;
          h_ra = bkt_q;
          state_d = S_LNK;
        end else state_d = S_EVAL;
      end
      S_EVAL: begin
        nx_d = n_rd; pv_d = p_rd; ob_d = b_rd;
        h_ra = b_rd;
        if (kind_q == KIND_QUERY) state_d = S_QHD;
        else if (b_rd == bkt_q) state_d = S_OUT;
        else begin
          b_we = 1'b1;
          state_d = S_MHD;
        end
      end
      S_QHD: begin
        res_x_d = (pv_q == NIL) && (nx_q == NIL) && (h_rd != {1'b0, ent_q});
        state_d = S_OUT;
      end
      S_MHD: begin
        if (h_rd == {1'b0, ent_q}) begin
          h_we = 1'b1; h_wa = ob_q; h_wd = nx_q;
          if (is_ent(nx_q)) begin
            p_we = 1'b1; p_wa = EA'(nx_q); p_wd = NIL;
          end
          state_d = S_LNK2;
        end else begin
          if (is_ent(pv_q)) begin
            n_we = 1'b1; n_wa = EA'(pv_q); n_wd = nx_q;
          end
          state_d = S_MNX;
        end
      end
      S_MNX: begin
        if (is_ent(nx_q)) begin
          p_we = 1'b1; p_wa = EA'(nx_q); p_wd = pv_q;
        end
        state_d = S_LNK2;
      end
      S_LNK2: begin
        h_ra = bkt_q;
        state_d = S_LNK;
      end
      S_LNK: begin
        // h_rd is the current head of bkt_q; own prev first, old head's prev after
        n_we = 1'b1; n_wd = h_rd;
        p_we = 1'b1; p_wd = NIL;
        h_we = 1'b1; h_wa = bkt_q; h_wd = {1'b0, ent_q};
        nx_d = h_rd;
        if (is_ent(h_rd)) state_d = S_PCHK2;
        else state_d = S_OUT;
        if ({1'b0, bkt_q} < low_q) low_d = {1'b0, bkt_q};
      end
      S_PCHK2: begin
        // old head now points back at the new one
        p_we = 1'b1; p_wa = EA'(nx_q); p_wd = {1'b0, ent_q};
        state_d = S_OUT;
      end
      S_PSCAN: begin
        if (low_q == BNONE) state_d = S_OUT;
        else begin
          h_ra = BA'(low_q);
          state_d = S_PHD;
        end
      end
      S_PHD: begin
        if (is_ent(h_rd)) begin
          ent_d = EA'(h_rd);
          n_ra = EA'(h_rd); b_ra = EA'(h_rd);
          state_d = S_PNX;
        end else begin
          low_d = low_q + 1'b1;
          state_d = S_PSCAN;
        end
      end
      S_PNX: begin
        nx_d = n_rd;
        h_we = 1'b1; h_wa = BA'(low_q); h_wd = n_rd;
        if (is_ent(n_rd)) begin
          p_we = 1'b1; p_wa = EA'(n_rd); p_wd = NIL;
        end
        ob_d = b_rd;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        n_we = 1'b1; n_wa = ent_q; n_wd = NIL;
        if ({1'b0, ob_q} != low_q) state_d = S_PSCAN;
        else begin
          res_e_d = ent_q; res_v_d = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      low_q <= BNONE;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      low_q <= low_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; ent_q <= ent_d; bkt_q <= bkt_d; ok_q <= ok_d;
    nx_q <= nx_d; pv_q <= pv_d; ob_q <= ob_d;
    res_e_q <= res_e_d; res_v_q <= res_v_d; res_x_q <= res_x_d;
  end
endmodule

// ----- tb/sv/bucket_priority_queue_core_tb.sv -----
// Self-checking testbench for bucket_priority_queue_core: push, move, pop and query
// requests against a linked-bucket predictor. Depends on bpq_pkg and the core.
`timescale 1ns / 1ps

import bpq_pkg::*;

typedef struct packed {
  logic [11:0] entry_out;
  logic        entry_valid;
  logic        already_expanded;
} bpq_result_t;

class bpq_scoreboard;
  localparam logic [12:0] NIL = 13'd4096;

  logic [12:0] head_q[256];
  logic [12:0] next_q[4096];
  logic [12:0] prev_q[4096];
  logic [7:0]  bkt_q[4096];
  logic [8:0]  lowest;
  bpq_result_t pending_q[$];
  int          errors;

  function new();
    foreach (head_q[i]) head_q[i] = NIL;
    foreach (next_q[i]) begin
      next_q[i] = '0;
      prev_q[i] = '0;
      bkt_q[i]  = '0;
    end
    lowest = 9'd256;
    errors = 0;
  endfunction

  function void link_front(logic [11:0] e, logic [7:0] b);
    logic [12:0] nx;
    nx = head_q[b];
    next_q[e] = nx;
    prev_q[e] = NIL;
    if (nx != NIL) prev_q[nx[11:0]] = {1'b0, e};
    head_q[b] = {1'b0, e};
    if ({1'b0, b} < lowest) lowest = {1'b0, b};
  endfunction

  function void relink(logic [11:0] e, logic [7:0] nb);
    logic [7:0]  ob;
    logic [12:0] nx, pv;
    ob = bkt_q[e];
    if (ob == nb) return;
    bkt_q[e] = nb;
    nx = next_q[e];
    pv = prev_q[e];
    if (head_q[ob] == {1'b0, e}) begin
      head_q[ob] = nx;
      if (nx != NIL) prev_q[nx[11:0]] = NIL;
    end else begin
      if (pv != NIL) next_q[pv[11:0]] = nx;
      if (nx != NIL) prev_q[nx[11:0]] = pv;
    end
    link_front(e, nb);
  endfunction

  // Drops stale heads on the way; returns the first head whose bucket matches.
  function bpq_result_t pop_lowest();
    bpq_result_t r;
    logic [12:0] s, nx;
    r = '0;
    while (lowest < 9'd256) begin
      s = head_q[lowest[7:0]];
      if (s != NIL) begin
        nx = next_q[s[11:0]];
        head_q[lowest[7:0]] = nx;
        if (nx != NIL) prev_q[nx[11:0]] = NIL;
        next_q[s[11:0]] = NIL;
        if ({1'b0, bkt_q[s[11:0]]} == lowest) begin
          r.entry_out   = s[11:0];
          r.entry_valid = 1'b1;
          return r;
        end
      end else begin
        lowest++;
      end
    end
    return r;
  endfunction

  function void note_request(kind_e kind, logic [11:0] e, logic [7:0] b);
    bpq_result_t r;
    logic [7:0] qb;
    r = '0;
    case (kind)
      KIND_PUSH: begin
        bkt_q[e] = b;
        link_front(e, b);
      end
      KIND_MOVE: relink(e, b);
      KIND_POP:  r = pop_lowest();
      default: begin
        qb = bkt_q[e];
        r.already_expanded = prev_q[e] == NIL && next_q[e] == NIL &&
                             head_q[qb] != {1'b0, e};
      end
    endcase
    pending_q.push_back(r);
  endfunction

  function void check_result(bpq_result_t act);
    bpq_result_t exp_r;
    if (pending_q.size() == 0) begin
      $error("unexpected result %p", act);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (act.entry_out !== exp_r.entry_out) begin
      $error("entry_out exp %0d got %0d", exp_r.entry_out, act.entry_out);
      errors++;
    end
    if (act.entry_valid !== exp_r.entry_valid) begin
      $error("entry_valid exp %0b got %0b", exp_r.entry_valid, act.entry_valid);
      errors++;
    end
    if (act.already_expanded !== exp_r.already_expanded) begin
      $error("already_expanded exp %0b got %0b", exp_r.already_expanded,
             act.already_expanded);
      errors++;
    end
  endfunction
endclass

module bucket_priority_queue_core_tb;
  localparam int STALL_LIMIT = 50000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [11:0] entry_i = '0;
  logic [7:0]  bucket_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] entry_out_o;
  logic        entry_valid_o;
  logic        already_expanded_o;

  bpq_scoreboard sb = new();
  bit            quiet = 1'b0;
  bit            pushed[4096];
  logic [11:0]   pushed_list[$];
  logic [11:0]   pool[$];
  int            idle_cnt = 0;

  bucket_priority_queue_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Result side: random stall and checking.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{entry_out_o, entry_valid_o, already_expanded_o});
    out_stall_i <= !quiet && ($urandom_range(99) < 6);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > STALL_LIMIT) begin
      $display("bucket_priority_queue_core_tb failed");
      $finish;
    end
  end

  task automatic send(kind_e kind, logic [11:0] e, logic [7:0] b);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    entry_i    <= e;
    bucket_i   <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, e, b);
    if (kind == KIND_PUSH && !pushed[e]) begin
      pushed[e] = 1'b1;
      pushed_list.push_back(e);
    end
  endtask

  function automatic logic [11:0] any_pushed();
    return pushed_list[$urandom_range(pushed_list.size() - 1)];
  endfunction

  initial begin
    int     r;
    kind_e  k;
    logic [11:0] e;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, same-bucket move, reopen, stale head, empty pop
    send(KIND_POP, 12'd0, 8'd0);
    send(KIND_PUSH, 12'd0, 8'd255);
    send(KIND_PUSH, 12'd4095, 8'd0);
    send(KIND_QUERY, 12'd4095, 8'd0);
    send(KIND_MOVE, 12'd4095, 8'd0);
    send(KIND_PUSH, 12'd2730, 8'd170);
    send(KIND_PUSH, 12'd1365, 8'd170);
    send(KIND_MOVE, 12'd2730, 8'd85);
    send(KIND_POP, 12'd0, 8'd0);
    send(KIND_QUERY, 12'd4095, 8'd0);
    send(KIND_MOVE, 12'd4095, 8'd3);
    send(KIND_PUSH, 12'd1365, 8'd1);
    send(KIND_QUERY, 12'd1365, 8'd0);
    send(KIND_POP, 12'd0, 8'd0);
    send(KIND_POP, 12'd0, 8'd0);
    send(KIND_POP, 12'd0, 8'd0);
    send(KIND_POP, 12'd0, 8'd0);
    send(KIND_POP, 12'd0, 8'd0);
    send(KIND_POP, 12'd0, 8'd0);
    send(KIND_QUERY, 12'd0, 8'd0);
    send(KIND_QUERY, 12'd2730, 8'd0);

    // small pool of entries so links get reused; full range of indices
    pool.push_back(12'd0);
    pool.push_back(12'd4095);
    repeat (40) pool.push_back(12'($urandom_range(4095)));

    for (int i = 0; i < 650; i++) begin
      quiet = (i >= 250 && i < 400);
      r = $urandom_range(99);
      if (pushed_list.size() == 0 || r < 35) k = KIND_PUSH;
      else if (r < 60) k = KIND_MOVE;
      else if (r < 85) k = KIND_POP;
      else k = KIND_QUERY;
      e = (k == KIND_PUSH) ? pool[$urandom_range(pool.size() - 1)] : any_pushed();
      // mostly low buckets so pops find work, sometimes any bucket
      send(k, e, ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(15)));
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("bucket_priority_queue_core_tb passed");
    else
      $display("bucket_priority_queue_core_tb failed");
    $finish;
  end
endmodule
